// File: rtl/rfd_pkg.sv
// ----------------------------------------------------------------------------
// rfd_pkg
// Shared types and codes for the radio event frame decoder: beat payloads,
// decoder state, phase, event and status codes.
// ----------------------------------------------------------------------------
package rfd_pkg;

   // Width of the payload byte counter (saturating)
   localparam int INDEX_BITS = 16;
   // Width of the reported byte position
   localparam int POS_BITS   = 16;

   // Header opcodes
   localparam logic [3:0] OPC_BLINK = 4'h0;
   localparam logic [3:0] OPC_RX    = 4'h1;
   localparam logic [3:0] OPC_TX    = 4'h2;
   localparam logic [3:0] OPC_RSSI  = 4'h3;
   localparam logic [3:0] OPC_SNR   = 4'h4;

   // Item command
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_EOF  = 1'b1;

   // Event kinds
   localparam logic [2:0] EV_NONE  = 3'd0;
   localparam logic [2:0] EV_RSSI  = 3'd1;
   localparam logic [2:0] EV_SNR   = 3'd2;
   localparam logic [2:0] EV_BLINK = 3'd3;
   localparam logic [2:0] EV_START = 3'd4;
   localparam logic [2:0] EV_DATA  = 3'd5;
   localparam logic [2:0] EV_END   = 3'd6;

   // Status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_UNKNOWN = 2'd1;
   localparam logic [1:0] ST_LENGTH  = 2'd2;
   localparam logic [1:0] ST_ABORTED = 2'd3;

   typedef enum logic [1:0] {
      PH_WAIT   = 2'd0,
      PH_FIXED  = 2'd1,
      PH_STREAM = 2'd2,
      PH_ABORT  = 2'd3
   } phase_type;

   typedef struct packed {
      logic       command;
      logic [7:0] data_in;
      logic       sink_reject;
   } req_item_type;

   typedef struct packed {
      logic [2:0]          event_kind;
      logic [1:0]          status;
      logic                error_reported;
      logic [3:0]          iface_num;
      logic [3:0]          event_opcode;
      logic signed [7:0]   signal_value;
      logic [7:0]          stream_byte;
      logic [POS_BITS-1:0] byte_position;
   } rsp_item_type;

   // Frame state carried from one beat to the next
   typedef struct packed {
      phase_type             phase;
      logic [3:0]            hdr_iface;
      logic [3:0]            hdr_opcode;
      logic                  exp_len;
      logic [INDEX_BITS-1:0] count;
   } frame_state_type;

   localparam frame_state_type FRAME_STATE_RESET = '{
      phase:      PH_WAIT,
      hdr_iface:  4'h0,
      hdr_opcode: 4'h0,
      exp_len:    1'b0,
      count:      '0
   };

endpackage

// File: rtl/radio_event_frame_decoder.sv
// ----------------------------------------------------------------------------
// radio_event_frame_decoder
// Decodes framed radio event bytes into RSSI, SNR, blink and stream events,
// reporting unknown opcodes, and length and consumer errors with the byte position.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+--------------------------
//   req_     | in        | req_valid / req_stall | req_item (rfd_pkg)
//   rsp_     | out       | rsp_valid / rsp_stall | rsp_item (rfd_pkg)
//
// One beat per cycle sustained while rsp_stall is low; an accepted beat reaches
// rsp_ through the input register, then the result register.
// The frame state advances as a beat moves from the input register into the
// result register; decode is a single combinational pass between the two.
// Reset clears valids and frame state; the held payload byte is not reset.
// rsp_stall holds the result register, then the input register, then req_.
//
module radio_event_frame_decoder (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rfd_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rfd_pkg::rsp_item_type rsp_item
);

   logic                     in_valid_ff;
   rfd_pkg::req_item_type    in_item_ff;
   logic                     out_valid_ff;
   rfd_pkg::rsp_item_type    out_item_ff;
   rfd_pkg::frame_state_type state_ff;
   rfd_pkg::frame_state_type state_in;
   logic [7:0]               held_ff;
   logic [7:0]               held_in;
   rfd_pkg::rsp_item_type    result;
   logic                     out_free;
   logic                     advance;

   // Result register can take a beat when empty or draining
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   rfd_decode u_decode (
      .item      (in_item_ff),
      .state_cur (state_ff),
      .held_cur  (held_ff),
      .state_nxt (state_in),
      .held_nxt  (held_in),
      .result    (result)
   );

   // Input register: load on accept, drop when the beat moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (!req_stall && req_valid) begin
         in_item_ff <= req_item;
      end
   end

   // Frame state and result register advance together
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rfd_pkg::FRAME_STATE_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            state_ff <= state_in;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
      end
      if (advance) begin
         held_ff     <= held_in;
         out_item_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   // A fixed frame never counts past its expected length
   a_fixed_count: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == rfd_pkg::PH_FIXED |->
         state_ff.count <= {{(rfd_pkg::INDEX_BITS-1){1'b0}}, state_ff.exp_len})
      else $error("fixed frame count beyond expected length");

   // An error report never carries an ok status
   a_err_status: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_item_ff.error_reported |->
         out_item_ff.status != rfd_pkg::ST_OK)
      else $error("error reported with ok status");

   // Position is only reported alongside an error
   a_pos_err: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_item_ff.error_reported |->
         out_item_ff.byte_position == '0)
      else $error("byte position without error");

   // A beat held in the input register stays until it moves on
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_item_ff))
      else $error("input register lost a stalled beat");

   // Frame state only changes when a beat is decoded
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("frame state changed without a beat");

endmodule

// File: rtl/rfd_decode.sv
// ----------------------------------------------------------------------------
// rfd_decode
// Single-pass decode of one beat: from the current frame state and held byte,
// form the result item, the next frame state and the next held byte.
// ----------------------------------------------------------------------------
module rfd_decode (
   input  rfd_pkg::req_item_type    item,
   input  rfd_pkg::frame_state_type state_cur,
   input  logic [7:0]               held_cur,
   output rfd_pkg::frame_state_type state_nxt,
   output logic [7:0]               held_nxt,
   output rfd_pkg::rsp_item_type    result
);

   localparam logic [rfd_pkg::INDEX_BITS-1:0] COUNT_MAX = '1;

   logic [rfd_pkg::INDEX_BITS-1:0] count_inc;
   logic [rfd_pkg::INDEX_BITS-1:0] exp_len_ext;
   logic [3:0]                     new_opcode;

   // Saturating increment and zero-extended expected length
   assign count_inc   = (state_cur.count == COUNT_MAX) ? state_cur.count
                                                       : state_cur.count + 1'b1;
   assign exp_len_ext = {{(rfd_pkg::INDEX_BITS-1){1'b0}}, state_cur.exp_len};
   assign new_opcode  = item.data_in[3:0];

   always_comb begin
      state_nxt = state_cur;
      held_nxt  = held_cur;

      result                = '0;
      result.event_kind     = rfd_pkg::EV_NONE;
      result.status         = rfd_pkg::ST_OK;
      result.error_reported = 1'b0;

      if (item.command == rfd_pkg::CMD_BYTE) begin
         case (state_cur.phase)
            // Header: latch interface and opcode, pick the frame shape
            rfd_pkg::PH_WAIT: begin
               state_nxt.hdr_iface  = item.data_in[7:4];
               state_nxt.hdr_opcode = new_opcode;
               state_nxt.count      = '0;
               if (new_opcode inside {rfd_pkg::OPC_RX, rfd_pkg::OPC_TX}) begin
                  state_nxt.exp_len = 1'b0;
                  state_nxt.phase   = rfd_pkg::PH_STREAM;
                  result.event_kind = rfd_pkg::EV_START;
               end else if (new_opcode inside {rfd_pkg::OPC_RSSI, rfd_pkg::OPC_SNR}) begin
                  state_nxt.exp_len = 1'b1;
                  state_nxt.phase   = rfd_pkg::PH_FIXED;
               end else if (new_opcode == rfd_pkg::OPC_BLINK) begin
                  state_nxt.exp_len = 1'b0;
                  state_nxt.phase   = rfd_pkg::PH_FIXED;
               end else begin
                  state_nxt.phase       = rfd_pkg::PH_ABORT;
                  result.status         = rfd_pkg::ST_UNKNOWN;
                  result.error_reported = 1'b1;
               end
            end
            // Fixed payload: hold the byte, or flag an extra one
            rfd_pkg::PH_FIXED: begin
               if (state_cur.count < exp_len_ext) begin
                  held_nxt        = item.data_in;
                  state_nxt.count = count_inc;
               end else begin
                  state_nxt.phase       = rfd_pkg::PH_ABORT;
                  result.status         = rfd_pkg::ST_LENGTH;
                  result.error_reported = 1'b1;
                  result.byte_position  = rfd_pkg::POS_BITS'(state_cur.count);
               end
            end
            // Stream: pass data through unless the consumer refuses it
            rfd_pkg::PH_STREAM: begin
               if (item.sink_reject) begin
                  state_nxt.phase       = rfd_pkg::PH_ABORT;
                  result.status         = rfd_pkg::ST_ABORTED;
                  result.error_reported = 1'b1;
                  result.byte_position  = rfd_pkg::POS_BITS'(state_cur.count);
               end else begin
                  result.event_kind  = rfd_pkg::EV_DATA;
                  result.stream_byte = item.data_in;
                  state_nxt.count    = count_inc;
               end
            end
            default: begin
               result.status = rfd_pkg::ST_ABORTED;
            end
         endcase
      end else begin
         // End of frame: close out, then wait for the next header (a rejected stream end stays aborted)
         state_nxt.phase = rfd_pkg::PH_WAIT;
         state_nxt.count = '0;
         case (state_cur.phase)
            rfd_pkg::PH_FIXED: begin
               if (state_cur.count == exp_len_ext) begin
                  if (state_cur.hdr_opcode == rfd_pkg::OPC_RSSI) begin
                     result.event_kind   = rfd_pkg::EV_RSSI;
                     result.signal_value = held_cur;
                  end else if (state_cur.hdr_opcode == rfd_pkg::OPC_SNR) begin
                     result.event_kind   = rfd_pkg::EV_SNR;
                     result.signal_value = held_cur;
                  end else begin
                     result.event_kind = rfd_pkg::EV_BLINK;
                  end
               end else begin
                  result.status         = rfd_pkg::ST_LENGTH;
                  result.error_reported = 1'b1;
                  result.byte_position  = rfd_pkg::POS_BITS'(state_cur.count);
               end
            end
            rfd_pkg::PH_STREAM: begin
               if (item.sink_reject) begin
                  // Rejected stream end stays aborted; count is kept
                  state_nxt.phase       = rfd_pkg::PH_ABORT;
                  state_nxt.count       = state_cur.count;
                  result.status         = rfd_pkg::ST_ABORTED;
                  result.error_reported = 1'b1;
                  result.byte_position  = rfd_pkg::POS_BITS'(state_cur.count);
               end else begin
                  result.event_kind = rfd_pkg::EV_END;
               end
            end
            default: begin
               result.status = rfd_pkg::ST_ABORTED;
            end
         endcase
      end

      result.iface_num    = state_nxt.hdr_iface;
      result.event_opcode = state_nxt.hdr_opcode;
   end

endmodule
